### sv/tlbpt_pkg.sv
// Package for the TLB page translation block: field widths and the result record.
// No dependencies; used by tlbpt_tag_array and tlb_page_translation.
package tlbpt_pkg;

  localparam int ADDR_W   = 32;
  localparam int MASKED_W = 16;
  localparam int PAGE_W   = 8;
  localparam int OFFSET_W = 8;
  localparam int COUNT_W  = 32;

  typedef logic [PAGE_W-1:0]   page_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [MASKED_W-1:0] masked_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // Translation outcome of one beat, handed from the lookup to the result register
  typedef struct packed {
    masked_t masked_address;
    page_t   page_number;
    offset_t page_offset;
    logic    tlb_hit;
    logic    page_fault;
  } result_t;

endpackage

### sv/tlbpt_tag_array.sv
// Fully associative TLB tag store with valid bits and first-in-first-out refill.
// Depends on tlbpt_pkg for the page type.
module tlbpt_tag_array #(
  parameter int TLB_ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  tlbpt_pkg::page_t lookup_page,
  input  logic            install,
  output logic            hit
);

  localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TLB_ENTRIES - 1);

  tlbpt_pkg::page_t       tags [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid;
  logic [IDX_W-1:0]       fill_ptr;
  logic [TLB_ENTRIES-1:0] match;

  // Compare the page against every entry in parallel
  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = valid[i] && (tags[i] == lookup_page);
    end
  end

  assign hit = |match;

  // Install at the fill pointer and advance it, wrapping after the last slot
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      fill_ptr <= '0;
    end else if (install) begin
      valid[fill_ptr] <= 1'b1;
      fill_ptr        <= (fill_ptr == LAST_SLOT) ? '0 : fill_ptr + IDX_W'(1);
    end
  end

  // Tags carry no reset: an entry is only looked at once its valid bit is set
  always_ff @(posedge clk) begin
    if (install) begin
      tags[fill_ptr] <= lookup_page;
    end
  end

endmodule

### sv/tlb_page_translation.sv
// Top level of the TLB page translation block: input register, TLB and page map
// lookup, result register. Depends on tlbpt_pkg and tlbpt_tag_array.
//
// Usage:
//   Input channel: in_valid / in_stall with virtual_address. A beat is taken at a
//   rising edge with in_valid high and in_stall low. Only the low 16 bits are used.
//   Output channel: out_valid / out_stall with the translation fields and the
//   three running counters. A beat leaves at an edge with out_valid high and
//   out_stall low.
//   Path: input register, then the TLB tag match, page map bit lookup and state
//   update in the same cycle into the result register. Throughput: one address
//   per cycle while out_stall is low, held because the TLB and the page map are
//   read and updated together in the same cycle.
//   Stall: while out_stall holds a result, the item in the input register waits
//   and in_stall rises; one new beat can still be taken when the input register
//   is empty.
//   Reset (rst, synchronous): TLB valid bits, fill pointer, page map, counters
//   and both valid flags clear together; no clearing pass is needed.
module tlb_page_translation #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tlbpt_pkg::ADDR_W-1:0]        virtual_address,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tlbpt_pkg::MASKED_W-1:0]      masked_address,
  output logic [tlbpt_pkg::PAGE_W-1:0]        page_number,
  output logic [tlbpt_pkg::OFFSET_W-1:0]      page_offset,
  output logic                                tlb_hit,
  output logic                                page_fault,
  output logic [tlbpt_pkg::COUNT_W-1:0]       address_count,
  output logic [tlbpt_pkg::COUNT_W-1:0]       hit_count,
  output logic [tlbpt_pkg::COUNT_W-1:0]       fault_count
);

  localparam int MAP_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int PAGE_SPACE = 1 << tlbpt_pkg::PAGE_W;

  logic                   s1_valid;
  tlbpt_pkg::masked_t     s1_addr;
  logic                   advance;
  tlbpt_pkg::page_t       s1_page;
  logic                   lookup_hit;
  logic [MAP_W-1:0]       map_idx;
  logic [MAP_W-1:0]       map_tbl [PAGE_SPACE];
  logic [PAGE_COUNT-1:0]  page_loaded;
  tlbpt_pkg::result_t     result;

  // Input register moves on when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_addr <= virtual_address[tlbpt_pkg::MASKED_W-1:0];
    end
  end

  assign s1_page = s1_addr[tlbpt_pkg::MASKED_W-1 -: tlbpt_pkg::PAGE_W];

  // TLB lookup; a miss installs the page as the beat advances
  tlbpt_tag_array #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_tags (
    .clk         (clk),
    .rst         (rst),
    .lookup_page (s1_page),
    .install     (advance && !lookup_hit),
    .hit         (lookup_hit)
  );

  // Page map index: page number folded onto the map size, fixed at elaboration
  for (genvar g = 0; g < PAGE_SPACE; g++) begin : g_map_tbl
    assign map_tbl[g] = MAP_W'(g % PAGE_COUNT);
  end

  assign map_idx = map_tbl[s1_page];

  always_comb begin
    result.masked_address = s1_addr;
    result.page_number    = s1_page;
    result.page_offset    = s1_addr[tlbpt_pkg::OFFSET_W-1:0];
    result.tlb_hit        = lookup_hit;
    result.page_fault     = !lookup_hit && !page_loaded[map_idx];
  end

  // Mark a faulting page loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      page_loaded <= '0;
    end else if (advance && result.page_fault) begin
      page_loaded[map_idx] <= 1'b1;
    end
  end

  // Result valid: set by an advancing beat, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Running counters double as the result's count fields
  always_ff @(posedge clk) begin
    if (rst) begin
      address_count <= '0;
      hit_count     <= '0;
      fault_count   <= '0;
    end else if (advance) begin
      address_count <= address_count + tlbpt_pkg::COUNT_W'(1);
      hit_count     <= hit_count + tlbpt_pkg::COUNT_W'(result.tlb_hit);
      fault_count   <= fault_count + tlbpt_pkg::COUNT_W'(result.page_fault);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      masked_address <= result.masked_address;
      page_number    <= result.page_number;
      page_offset    <= result.page_offset;
      tlb_hit        <= result.tlb_hit;
      page_fault     <= result.page_fault;
    end
  end

endmodule

### sv/tlbpt_checker.sv
// Port-level checker for tlb_page_translation, attached by the bind below.
// Depends only on the top level's ports.
module tlbpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] masked_address,
  input logic [7:0]  page_number,
  input logic [7:0]  page_offset,
  input logic        tlb_hit,
  input logic        page_fault,
  input logic [31:0] address_count,
  input logic [31:0] hit_count,
  input logic [31:0] fault_count
);

  // A stalled result beat holds its fields
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(masked_address)
      && $stable(address_count) && $stable(tlb_hit) && $stable(page_fault))
    else $error("stalled result beat changed");

  // Page and offset split the masked address; a hit never faults
  a_split: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> page_number == masked_address[15:8]
      && page_offset == masked_address[7:0] && !(tlb_hit && page_fault))
    else $error("inconsistent translation fields");

  // Consecutive result beats step the address count by one
  a_addr_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) ##1 out_valid
      |-> address_count == $past(address_count) + 32'd1)
    else $error("address count skipped or repeated");

  // Hit and fault counts advance by exactly the flags of the new beat
  a_flag_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) ##1 out_valid
      |-> hit_count == $past(hit_count) + {31'b0, tlb_hit}
        && fault_count == $past(fault_count) + {31'b0, page_fault})
    else $error("hit or fault count out of step");

endmodule

bind tlb_page_translation tlbpt_checker u_tlbpt_checker (.*);

### tb/tlb_page_translation_tb.sv
// Self-checking testbench for tlb_page_translation: directed TLB fill and eviction
// beats, then random addresses over a hot page pool under source and sink idling.
// Depends on tlbpt_pkg and the tlb_page_translation RTL.
module tlb_page_translation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TLB_DEPTH   = 16;
  localparam int MAP_PAGES   = 256;
  localparam int HOT_PAGES   = 20;
  localparam int PHASE_BEATS = 400;
  localparam int SINK_HOLD   = 60;
  localparam int DRAIN_WAIT  = 10;
  localparam int CYCLE_LIMIT = 200000;

  // One translated beat as it leaves the block
  typedef struct packed {
    tlbpt_pkg::result_t xlat;
    tlbpt_pkg::count_t  address_count;
    tlbpt_pkg::count_t  hit_count;
    tlbpt_pkg::count_t  fault_count;
  } xlat_beat_t;

  // Tracks TLB and page map state, predicts each translation and checks results
  class translation_scoreboard;
    tlbpt_pkg::page_t  tag [TLB_DEPTH];
    bit                tag_valid [TLB_DEPTH];
    int                fill_slot;
    bit                loaded [MAP_PAGES];
    tlbpt_pkg::count_t addresses_seen;
    tlbpt_pkg::count_t hits_seen;
    tlbpt_pkg::count_t faults_seen;
    xlat_beat_t        expected_q[$];
    int                failures;

    function new();
      fill_slot = 0;
      addresses_seen = '0;
      hits_seen = '0;
      faults_seen = '0;
      failures = 0;
      foreach (tag[i]) begin
        tag[i] = '0;
        tag_valid[i] = 1'b0;
      end
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Translate one accepted address and queue the expected beat
    function void note_address(logic [tlbpt_pkg::ADDR_W-1:0] va);
      xlat_beat_t       want;
      tlbpt_pkg::page_t page;
      logic             hit;
      int               map_idx;
      page = va[15:8];
      hit = 1'b0;
      want.xlat.masked_address = va[15:0];
      want.xlat.page_number = page;
      want.xlat.page_offset = va[7:0];
      want.xlat.page_fault = 1'b0;
      addresses_seen = addresses_seen + 1;
      for (int i = 0; i < TLB_DEPTH; i++) begin
        if (tag_valid[i] && tag[i] == page) hit = 1'b1;
      end
      if (hit) begin
        hits_seen = hits_seen + 1;
      end else begin
        map_idx = int'(page) % MAP_PAGES;
        if (!loaded[map_idx]) begin
          want.xlat.page_fault = 1'b1;
          faults_seen = faults_seen + 1;
          loaded[map_idx] = 1'b1;
        end
        // install at the oldest slot, first in first out
        tag[fill_slot] = page;
        tag_valid[fill_slot] = 1'b1;
        fill_slot = (fill_slot + 1) % TLB_DEPTH;
      end
      want.xlat.tlb_hit = hit;
      want.address_count = addresses_seen;
      want.hit_count = hits_seen;
      want.fault_count = faults_seen;
      expected_q.push_back(want);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= 10)
          $display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $realtime, field, want, got);
      end
    endfunction

    // Compare one delivered beat against the oldest prediction
    function void check_result(xlat_beat_t got);
      xlat_beat_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result beat, masked_address 0x%0h", $realtime,
                   got.xlat.masked_address);
        return;
      end
      want = expected_q.pop_front();
      compare_field("masked_address", want.xlat.masked_address, got.xlat.masked_address);
      compare_field("page_number", want.xlat.page_number, got.xlat.page_number);
      compare_field("page_offset", want.xlat.page_offset, got.xlat.page_offset);
      compare_field("tlb_hit", want.xlat.tlb_hit, got.xlat.tlb_hit);
      compare_field("page_fault", want.xlat.page_fault, got.xlat.page_fault);
      compare_field("address_count", want.address_count, got.address_count);
      compare_field("hit_count", want.hit_count, got.hit_count);
      compare_field("fault_count", want.fault_count, got.fault_count);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [tlbpt_pkg::ADDR_W-1:0]   virtual_address = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [tlbpt_pkg::MASKED_W-1:0] masked_address;
  logic [tlbpt_pkg::PAGE_W-1:0]   page_number;
  logic [tlbpt_pkg::OFFSET_W-1:0] page_offset;
  logic                           tlb_hit;
  logic                           page_fault;
  logic [tlbpt_pkg::COUNT_W-1:0]  address_count;
  logic [tlbpt_pkg::COUNT_W-1:0]  hit_count;
  logic [tlbpt_pkg::COUNT_W-1:0]  fault_count;

  translation_scoreboard xlat_sb = new();

  int               src_idle_pct = 0;
  int               sink_idle_pct = 0;
  bit               hold_trigger = 1'b0;
  bit               hold_started = 1'b0;
  int               hold_left = 0;
  int               cycles = 0;
  tlbpt_pkg::page_t hot_page [HOT_PAGES];

  tlb_page_translation dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .virtual_address (virtual_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .masked_address  (masked_address),
    .page_number     (page_number),
    .page_offset     (page_offset),
    .tlb_hit         (tlb_hit),
    .page_fault      (page_fault),
    .address_count   (address_count),
    .hit_count       (hit_count),
    .fault_count     (fault_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drive the sink stall: one long hold when triggered, random idling otherwise
  always @(negedge clk) begin
    if (hold_trigger && !hold_started) begin
      hold_started = 1'b1;
      hold_left = SINK_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
    end
  end

  // Check every result beat that leaves the block
  always @(posedge clk) begin
    xlat_beat_t got;
    if (!rst && out_valid && !out_stall) begin
      got.xlat.masked_address = masked_address;
      got.xlat.page_number = page_number;
      got.xlat.page_offset = page_offset;
      got.xlat.tlb_hit = tlb_hit;
      got.xlat.page_fault = page_fault;
      got.address_count = address_count;
      got.hit_count = hit_count;
      got.fault_count = fault_count;
      xlat_sb.check_result(got);
    end
  end

  // Offer one address beat; called and returns at a falling edge
  task automatic send_address(input logic [tlbpt_pkg::ADDR_W-1:0] va);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      virtual_address <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    virtual_address <= va;
    do @(posedge clk); while (in_stall);
    xlat_sb.note_address(va);
    @(negedge clk);
  endtask

  // Hold the source until every predicted result has been delivered
  task automatic drain_results();
    in_valid <= 1'b0;
    while (xlat_sb.pending() != 0) @(negedge clk);
  endtask

  task automatic pick_hot_pages();
    foreach (hot_page[i]) hot_page[i] = tlbpt_pkg::page_t'($urandom_range(0, 255));
  endtask

  // Mostly hot pages with random offsets and upper bits, some fully random
  function automatic logic [tlbpt_pkg::ADDR_W-1:0] random_address();
    logic [tlbpt_pkg::ADDR_W-1:0] va;
    va = $urandom;
    if ($urandom_range(0, 9) < 7) va[15:8] = hot_page[$urandom_range(0, HOT_PAGES - 1)];
    return va;
  endfunction

  task automatic run_phase(input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    pick_hot_pages();
    for (int n = 0; n < PHASE_BEATS; n++) send_address(random_address());
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, ignored upper bits, TLB fill, FIFO eviction, reload
    src_idle_pct = 23;
    sink_idle_pct = 60;
    send_address(32'h0000_0000);
    send_address(32'hFFFF_0000);
    send_address(32'h0000_FFFF);
    send_address(32'hFFFF_FFFF);
    for (int p = 1; p <= 14; p++)
      send_address({8'h5A, 8'(p), 8'(p), ~8'(p)});
    send_address(32'h0000_0F80);
    send_address(32'h0001_0011);
    send_address(32'h0000_0102);
    send_address(32'hAAAA_FF55);
    send_address(32'h1234_5678);
    drain_results();

    run_phase(23, 60);
    run_phase(60, 23);
    // sink holds off for a long stretch while the source keeps offering
    hold_trigger = 1'b1;
    run_phase(0, 0);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (xlat_sb.failures == 0 && xlat_sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
